/* sv/swsb_pkg.sv */
// Shared types and sizing constants for the sliding window sample buffer.
// Depends on nothing; every other file imports this package.
package swsb_pkg;

  // window length in samples (legal range 2 to 64)
  localparam int unsigned Window   = 64;
  localparam int unsigned PtrW     = $clog2(Window);
  localparam int unsigned FillW    = $clog2(Window + 1);

  // output queue depth and its pointer and count widths
  localparam int unsigned OutDepth = 2;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  // one input request
  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               chunk_end;
  } in_t;

  // one output request
  typedef struct packed {
    logic signed [15:0] window_sample;
    logic               window_last;
  } out_t;

  // output queue status seen by the read sequencer
  typedef struct packed {
    logic [OutCntW-1:0] count;
    logic               pop;
  } fifo_stat_t;

endpackage

/* sv/swsb_out_fifo.sv */
// Small output queue that decouples ring reads from downstream stall.
// Depends on swsb_pkg for the request type and the queue depth.
module swsb_out_fifo import swsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  out_t       push_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  output fifo_stat_t stat_o
);

  out_t               entry_q [OutDepth];
  logic [OutPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OutPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0] count_q, count_d;
  logic               pop;

  // handshake toward the consumer
  assign out_valid_o  = (count_q != '0);
  assign out_data_o   = entry_q[rd_ptr_q];
  assign pop          = out_valid_o && !out_stall_i;
  assign stat_o.count = count_q;
  assign stat_o.pop   = pop;

  // pointer and count updates
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OutPtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == OutPtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/sliding_window_sample_buffer.sv */
// Readout: a chunk-end request that completes a full window starts a readout through the state
// register, the registered ring read and the output queue; one result per cycle unless the output stalls.
// Throughput: one sample per cycle between emissions; an emission holds the input stalled
// until all Window samples are read (one ring read port, one read per cycle while the queue has room).
// Reset: pointer, fill count and control clear at once; the ring is not cleared, since a
// window is read only after Window samples have been written.
// Depends on swsb_pkg and swsb_out_fifo.
module sliding_window_sample_buffer import swsb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic               state_q, state_d;
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]    rd_idx_q, rd_idx_d;
  logic               rd_vld_q;
  logic               rd_last_q;
  logic signed [15:0] rdata_q;
  logic signed [15:0] ring [Window];

  logic               in_accept;
  logic               rd_issue;
  logic               idx_last;
  logic [OutCntW:0]   in_flight;
  fifo_stat_t         fifo_stat;
  out_t               push_data;

  // input handshake: stalled while the ring is being read out
  assign in_stall_o = (state_q == StEmit);
  assign in_accept  = in_valid_i && !in_stall_o;

  // read only while the output queue has a free slot for the result
  assign in_flight = {1'b0, fifo_stat.count} + {{OutCntW{1'b0}}, rd_vld_q};
  assign rd_issue  = (state_q == StEmit) &&
                     ((in_flight < (OutCntW + 1)'(OutDepth)) || fifo_stat.pop);
  assign idx_last  = (rd_idx_q == PtrW'(Window - 1));

  // write side and read sequencer
  always_comb begin
    state_d  = state_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    rd_ptr_d = rd_ptr_q;
    rd_idx_d = rd_idx_q;
    if (in_accept) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Window - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (fill_q != FillW'(Window)) begin
        fill_d = fill_q + 1'b1;
      end
      // oldest sample sits at the slot after the one just written
      if (in_data_i.chunk_end && (fill_d == FillW'(Window))) begin
        state_d  = StEmit;
        rd_ptr_d = wr_ptr_d;
        rd_idx_d = '0;
      end
    end
    if (rd_issue) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Window - 1)) ? '0 : rd_ptr_q + 1'b1;
      rd_idx_d = rd_idx_q + 1'b1;
      if (idx_last) begin
        state_d = StIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      wr_ptr_q  <= '0;
      fill_q    <= '0;
      rd_ptr_q  <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_ptr_q  <= wr_ptr_d;
      fill_q    <= fill_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_issue;
      rd_last_q <= rd_issue && idx_last;
    end
  end

  // sample ring, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ring[wr_ptr_q] <= in_data_i.sample_in;
    end
    if (rd_issue) begin
      rdata_q <= ring[rd_ptr_q];
    end
  end

  // read data enters the output queue in the cycle after the read
  assign push_data.window_sample = rdata_q;
  assign push_data.window_last   = rd_last_q;

  swsb_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rd_vld_q),
    .push_data_i (push_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .stat_o      (fifo_stat)
  );

  // queued plus pending reads never exceed the queue depth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight <= (OutCntW + 1)'(OutDepth))
    else $error("output queue overcommitted");

  // an emission starts only once the window is full
  a_full_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q) |-> fill_q == FillW'(Window))
    else $error("emission started before window filled");

  // the last read of a window ends the emission
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue && idx_last |=> state_q == StIdle && rd_last_q)
    else $error("emission did not end on last read");

  // no ring write while a readout is in progress
  a_no_write_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> !in_accept ##1 $stable(wr_ptr_q))
    else $error("ring written during readout");

endmodule
